// ===== src/rau_pkg.sv =====
// rau_pkg: shared constants and types for the rational arithmetic unit
// no dependencies
`default_nettype none
package rau_pkg;
   localparam int WORD_BITS_DEF = 32;
   localparam int MAG_BITS      = 64;

   localparam logic [2:0] CMD_NORM = 3'd0;
   localparam logic [2:0] CMD_ADD  = 3'd1;
   localparam logic [2:0] CMD_SUB  = 3'd2;
   localparam logic [2:0] CMD_MUL  = 3'd3;
   localparam logic [2:0] CMD_DIV  = 3'd4;
   localparam logic [2:0] CMD_CMP  = 3'd5;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_ZDEN = 2'd1;
   localparam logic [1:0] ST_DIV0 = 2'd2;
   localparam logic [1:0] ST_OVF  = 2'd3;

   typedef struct packed {
      logic        start;
      logic [63:0] x;
      logic [63:0] y;
   } gcd_req_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      logic [63:0] g;
   } gcd_rsp_type;
endpackage
`default_nettype wire

// ===== src/rau_gcd.sv =====
// rau_gcd: iterative binary gcd over 64-bit magnitudes, one step per cycle
// depends on rau_pkg
`default_nettype none
module rau_gcd (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire rau_pkg::gcd_req_type req,
   output rau_pkg::gcd_rsp_type      rsp
);
   logic [63:0] x_ff, x_in, y_ff, y_in;
   logic [6:0]  k_ff, k_in;
   logic        busy_ff, busy_in, done_ff, done_in;

   // x kept odd once stripped; y reduced by subtract and shift
   always_comb begin
      x_in = x_ff; y_in = y_ff; k_in = k_ff;
      busy_in = busy_ff; done_in = 1'b0;
      if (req.start) begin
         x_in = req.x; y_in = req.y; k_in = '0; busy_in = 1'b1;
      end else if (busy_ff) begin
         if (y_ff == '0) begin
            x_in = x_ff << k_ff[5:0];
            busy_in = 1'b0; done_in = 1'b1;
         end else if (!x_ff[0] && !y_ff[0]) begin
            x_in = x_ff >> 1; y_in = y_ff >> 1; k_in = k_ff + 7'd1;
         end else if (!x_ff[0]) begin
            x_in = x_ff >> 1;
         end else if (!y_ff[0]) begin
            y_in = y_ff >> 1;
         end else if (y_ff >= x_ff) begin
            y_in = (y_ff - x_ff) >> 1;
         end else begin
            x_in = y_ff; y_in = (x_ff - y_ff) >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in; y_ff <= y_in; k_ff <= k_in;
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
   end

   assign rsp.busy = busy_ff;
   assign rsp.done = done_ff;
   assign rsp.g    = x_ff;

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("gcd done without busy");
   a_not_both: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("gcd done while busy");
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      req.start |=> busy_ff) else $error("gcd start lost");
endmodule
`default_nettype wire

// ===== src/rau_div.sv =====
// rau_div: restoring 64-bit divider, one quotient bit per cycle
// depends on rau_pkg
`default_nettype none
module rau_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] dividend,
   input  wire logic [63:0] divisor,
   output logic             done,
   output logic [63:0]      quotient
);
   logic [63:0] q_ff, q_in, d_ff, d_in;
   logic [64:0] r_ff, r_in, trial;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;

   always_comb begin
      q_in = q_ff; d_in = d_ff; r_in = r_ff; cnt_in = cnt_ff;
      busy_in = busy_ff; done_in = 1'b0;
      trial = {r_ff[63:0], q_ff[63]} - {1'b0, d_ff};
      if (start) begin
         q_in = dividend; d_in = divisor; r_in = '0; cnt_in = '0; busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial[64]) begin
            r_in = {r_ff[63:0], q_ff[63]}; q_in = {q_ff[62:0], 1'b0};
         end else begin
            r_in = trial; q_in = {q_ff[62:0], 1'b1};
         end
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'd63) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in; d_ff <= d_in; r_ff <= r_in; cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = q_ff;
endmodule
`default_nettype wire

// ===== src/rational_arithmetic_unit.sv =====
// rational_arithmetic_unit: top level, sequencer around a shared multiplier,
// a binary gcd unit and a shared bit-serial divider; depends on rau_pkg
`default_nettype none
// One transaction at a time. A request is taken when the unit is idle; it
// forms cross products with a 32x32 multiplier used up to three times (one
// product per cycle), runs a binary gcd on the 64-bit numerator and
// denominator magnitudes (one step per cycle), then divides numerator and
// denominator by the gcd one after the other on one restoring divider.
// Compare and error cases skip the gcd and the divider.
// The result sits in an output register until taken, and req_tready stays
// low from acceptance until the result transaction completes.
module rational_arithmetic_unit #(
   parameter int WORD_BITS = rau_pkg::WORD_BITS_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // a_num[31:0], a_den[63:32], b_num[95:64], b_den[127:96]
   input  wire logic [127:0] req_tdata,
   // cmd[2:0]
   input  wire logic [2:0]   req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // res_num[31:0], res_den[62:32], less[63], equal[64], status[66:65], zero pad
   output logic [71:0]       rsp_tdata
);
   localparam logic [3:0] S_IDLE = 4'd0, S_M1 = 4'd1, S_M2 = 4'd2, S_M3 = 4'd3,
                          S_COMB = 4'd4, S_GCD = 4'd5, S_GW = 4'd6,
                          S_DN = 4'd7, S_DNW = 4'd8, S_DD = 4'd9, S_DDW = 4'd10,
                          S_FIN = 4'd11, S_OUT = 4'd12;

   logic [3:0]  state_ff, state_in;
   logic [2:0]  cmd_ff, cmd_in;
   logic        an_s_ff, bn_s_ff;
   logic        an_s_in, bn_s_in;
   logic [31:0] an_ff, ad_ff, bn_ff, bd_ff, an_in, ad_in, bn_in, bd_in;
   logic [63:0] p1_ff, p1_in, p2_ff, p2_in, n_ff, n_in, d_ff, d_in;
   logic        p1s_ff, p1s_in, p2s_ff, p2s_in, ns_ff, ns_in;
   logic [63:0] g_ff, g_in;
   logic [31:0] res_num_ff, res_num_in;
   logic [30:0] res_den_ff, res_den_in;
   logic        less_ff, less_in, equal_ff, equal_in;
   logic [1:0]  status_ff, status_in;

   // operand sign/magnitude load, low WORD_BITS sign extended
   function automatic logic [32:0] load_w(input logic [31:0] raw);
      logic [WORD_BITS-1:0] v;
      logic [WORD_BITS-1:0] m;
      v = raw[WORD_BITS-1:0];
      m = v[WORD_BITS-1] ? (~v + 1'b1) : v;
      return {v[WORD_BITS-1], 32'(m)};
   endfunction

   logic [32:0] la_n, la_d, lb_n, lb_d;
   assign la_n = load_w(req_tdata[31:0]);
   assign la_d = load_w(req_tdata[63:32]);
   assign lb_n = load_w(req_tdata[95:64]);
   assign lb_d = load_w(req_tdata[127:96]);

   // shared multiplier operand select
   logic [31:0] mx, my;
   logic [63:0] prod;
   always_comb begin
      case (state_ff)
         S_M1:    begin mx = an_ff; my = (cmd_ff == rau_pkg::CMD_MUL) ? bn_ff : bd_ff; end
         S_M2:    begin
            mx = (cmd_ff == rau_pkg::CMD_MUL) ? ad_ff : bn_ff;
            my = (cmd_ff == rau_pkg::CMD_MUL) ? bd_ff : ad_ff;
         end
         default: begin mx = ad_ff; my = bd_ff; end
      endcase
   end
   assign prod = mx * my;

   rau_pkg::gcd_req_type greq;
   rau_pkg::gcd_rsp_type grsp;
   assign greq.start = (state_ff == S_GCD);
   assign greq.x     = n_ff;
   assign greq.y     = d_ff;
   rau_gcd u_gcd (.clock(clock), .reset(reset), .req(greq), .rsp(grsp));

   logic        dv_start, dv_done;
   logic [63:0] dv_q;
   assign dv_start = (state_ff == S_DN) || (state_ff == S_DD);
   rau_div u_div (.clock(clock), .reset(reset), .start(dv_start),
      .dividend((state_ff == S_DN) ? n_ff : d_ff), .divisor(g_ff),
      .done(dv_done), .quotient(dv_q));

   logic [63:0] lim;
   assign lim = 64'd1 << (WORD_BITS - 1);

   always_comb begin
      state_in = state_ff; cmd_in = cmd_ff;
      an_in = an_ff; ad_in = ad_ff; bn_in = bn_ff; bd_in = bd_ff;
      an_s_in = an_s_ff; bn_s_in = bn_s_ff;
      p1_in = p1_ff; p2_in = p2_ff; p1s_in = p1s_ff; p2s_in = p2s_ff;
      n_in = n_ff; d_in = d_ff; ns_in = ns_ff; g_in = g_ff;
      res_num_in = res_num_ff; res_den_in = res_den_ff;
      less_in = less_ff; equal_in = equal_ff; status_in = status_ff;
      case (state_ff)
         S_IDLE: if (req_tvalid) begin
            cmd_in = req_tuser;
            // denominators made positive, sign moved to numerator
            an_in = la_n[31:0]; ad_in = la_d[31:0];
            bn_in = lb_n[31:0]; bd_in = lb_d[31:0];
            an_s_in = (la_n[32] ^ la_d[32]) && (la_n[31:0] != '0);
            bn_s_in = (lb_n[32] ^ lb_d[32]) && (lb_n[31:0] != '0);
            res_num_in = '0; res_den_in = '0; less_in = 1'b0; equal_in = 1'b0;
            status_in = rau_pkg::ST_OK;
            if (req_tuser > rau_pkg::CMD_CMP) begin
               state_in = S_OUT;
            end else if (la_d[31:0] == '0 ||
                         (req_tuser != rau_pkg::CMD_NORM && lb_d[31:0] == '0)) begin
               status_in = rau_pkg::ST_ZDEN; state_in = S_OUT;
            end else if (req_tuser == rau_pkg::CMD_DIV && lb_n[31:0] == '0) begin
               status_in = rau_pkg::ST_DIV0; state_in = S_OUT;
            end else if (req_tuser == rau_pkg::CMD_NORM) begin
               state_in = S_COMB;
            end else begin
               state_in = S_M1;
            end
         end
         S_M1: begin
            p1_in = prod;
            p1s_in = an_s_ff ^ ((cmd_ff == rau_pkg::CMD_MUL) ? bn_s_ff : 1'b0);
            state_in = S_M2;
         end
         S_M2: begin
            p2_in = prod;
            p2s_in = (cmd_ff == rau_pkg::CMD_MUL) ? 1'b0 :
                     (bn_s_ff ^ (cmd_ff == rau_pkg::CMD_SUB ||
                                 cmd_ff == rau_pkg::CMD_CMP));
            state_in = (cmd_ff == rau_pkg::CMD_MUL) ? S_COMB : S_M3;
         end
         S_M3: begin
            // divide uses ad*bn as denominator with bn sign
            if (cmd_ff == rau_pkg::CMD_DIV) begin
               p2_in = p2_ff; p2s_in = bn_s_ff;
            end else begin
               d_in = prod;
            end
            state_in = S_COMB;
         end
         S_COMB: begin
            state_in = S_GCD;
            case (cmd_ff)
               rau_pkg::CMD_NORM: begin n_in = {32'd0, an_ff}; ns_in = an_s_ff;
                  d_in = {32'd0, ad_ff}; end
               rau_pkg::CMD_MUL: begin n_in = p1_ff; ns_in = p1s_ff; d_in = p2_ff; end
               rau_pkg::CMD_DIV: begin n_in = p1_ff; ns_in = an_s_ff ^ bn_s_ff;
                  d_in = p2_ff; end
               default: begin
                  // add/sub/compare: signed magnitude sum of cross products
                  if (p1s_ff == p2s_ff) begin
                     n_in = p1_ff + p2_ff; ns_in = p1s_ff;
                  end else if (p1_ff >= p2_ff) begin
                     n_in = p1_ff - p2_ff; ns_in = p1s_ff;
                  end else begin
                     n_in = p2_ff - p1_ff; ns_in = p2s_ff;
                  end
                  if (cmd_ff == rau_pkg::CMD_CMP) begin
                     less_in  = ns_in && (n_in != '0);
                     equal_in = (n_in == '0);
                     state_in = S_OUT;
                  end
               end
            endcase
            if (n_in == '0 && cmd_ff != rau_pkg::CMD_CMP) begin
               n_in = '0; ns_in = 1'b0; d_in = 64'd1; state_in = S_FIN;
            end
         end
         S_GCD: state_in = S_GW;
         S_GW: if (grsp.done) begin g_in = grsp.g; state_in = S_DN; end
         S_DN: state_in = S_DNW;
         S_DNW: if (dv_done) begin n_in = dv_q; state_in = S_DD; end
         S_DD: state_in = S_DDW;
         S_DDW: if (dv_done) begin d_in = dv_q; state_in = S_FIN; end
         S_FIN: begin
            if ((ns_ff ? (n_ff > lim) : (n_ff > lim - 64'd1)) || d_ff > lim - 64'd1) begin
               status_in = rau_pkg::ST_OVF;
            end else begin
               res_num_in = ns_ff ? (32'd0 - n_ff[31:0]) : n_ff[31:0];
               res_den_in = d_ff[30:0];
            end
            state_in = S_OUT;
         end
         S_OUT: if (rsp_tready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in; an_ff <= an_in; ad_ff <= ad_in; bn_ff <= bn_in; bd_ff <= bd_in;
      an_s_ff <= an_s_in; bn_s_ff <= bn_s_in;
      p1_ff <= p1_in; p2_ff <= p2_in; p1s_ff <= p1s_in; p2s_ff <= p2s_in;
      n_ff <= n_in; d_ff <= d_in; ns_ff <= ns_in; g_ff <= g_in;
      res_num_ff <= res_num_in; res_den_ff <= res_den_in;
      less_ff <= less_in; equal_ff <= equal_in; status_ff <= status_in;
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tdata  = {5'd0, status_ff, equal_ff, less_ff, res_den_ff, res_num_ff};

   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid)) else $error("ready while result pending");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");
   a_cmp_only: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (less_ff || equal_ff) |-> cmd_ff == rau_pkg::CMD_CMP)
      else $error("flags on non compare");
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && status_ff != rau_pkg::ST_OK |-> res_num_ff == '0 && res_den_ff == '0)
      else $error("payload on error");
endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// testbench for rational_arithmetic_unit: drives fraction requests over the req stream,
// predicts each result with an exact sign-magnitude model and checks the rsp stream
// depends on rau_pkg and the rational_arithmetic_unit rtl
`default_nettype none
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [31:0] a_num;
      logic [31:0] a_den;
      logic [31:0] b_num;
      logic [31:0] b_den;
   } frac_req_type;

   typedef struct packed {
      logic [31:0] num;
      logic [30:0] den;
      logic        less;
      logic        equal;
      logic [1:0]  status;
   } frac_rsp_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [127:0] req_tdata;
   logic [2:0]   req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [71:0]  rsp_tdata;

   frac_req_type pending_reqs[$];
   frac_rsp_type expected_fracs[$];
   int        send_idle_pct;
   int        recv_stall_pct;
   int        error_count;
   longint    cycle_count;
   bit        stim_done;
   bit        req_fire;

   rational_arithmetic_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // exact signed product: 32x32 magnitudes never exceed 64 bits
   function automatic void mul_sm(input bit xn, input logic [63:0] xm, input bit yn,
                                  input logic [63:0] ym, output bit rn, output logic [63:0] rm);
      rm = xm * ym;
      rn = (rm != 0) && (xn != yn);
   endfunction

   function automatic void add_sm(input bit xn, input logic [63:0] xm, input bit yn,
                                  input logic [63:0] ym, output bit rn, output logic [63:0] rm);
      if (xn == yn) begin
         rn = xn;
         rm = xm + ym;
      end else if (xm >= ym) begin
         rn = xn;
         rm = xm - ym;
      end else begin
         rn = yn;
         rm = ym - xm;
      end
      if (rm == 0) rn = 1'b0;
   endfunction

   // reduce by gcd and range check, returns status
   function automatic logic [1:0] reduce_frac(input bit nn, input logic [63:0] nm, input bit dn,
                                              input logic [63:0] dm, inout frac_rsp_type r);
      bit          neg;
      logic [63:0] x;
      logic [63:0] y;
      logic [63:0] t;
      neg = nn != dn;
      if (nm == 0) begin
         neg = 1'b0;
         dm = 64'd1;
      end else begin
         x = nm;
         y = dm;
         while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
         end
         nm = nm / x;
         dm = dm / x;
      end
      if ((neg ? nm > 64'h8000_0000 : nm > 64'h7FFF_FFFF) || dm > 64'h7FFF_FFFF)
         return rau_pkg::ST_OVF;
      r.num = neg ? 32'(-nm) : nm[31:0];
      r.den = dm[30:0];
      return rau_pkg::ST_OK;
   endfunction

   function automatic frac_rsp_type predict_frac(frac_req_type q);
      frac_rsp_type r;
      bit          an_n, ad_n, bn_n, bd_n, n1, n2, nn, dn;
      logic [63:0] an_m, ad_m, bn_m, bd_m, m1, m2, nm, dm;
      logic [1:0]  st;
      r = '0;
      st = rau_pkg::ST_OK;
      an_n = q.a_num[31]; an_m = an_n ? 64'(-q.a_num) : 64'(q.a_num);
      ad_n = q.a_den[31]; ad_m = ad_n ? 64'(-q.a_den) : 64'(q.a_den);
      bn_n = q.b_num[31]; bn_m = bn_n ? 64'(-q.b_num) : 64'(q.b_num);
      bd_n = q.b_den[31]; bd_m = bd_n ? 64'(-q.b_den) : 64'(q.b_den);
      an_m[63:32] = '0; ad_m[63:32] = '0; bn_m[63:32] = '0; bd_m[63:32] = '0;
      if (q.cmd > rau_pkg::CMD_CMP) return r;
      if (ad_m == 0 || (q.cmd != rau_pkg::CMD_NORM && bd_m == 0)) begin
         r.status = rau_pkg::ST_ZDEN;
         return r;
      end
      // move denominator signs onto numerators
      if (ad_n) begin an_n = !an_n && an_m != 0; ad_n = 1'b0; end
      if (bd_n) begin bn_n = !bn_n && bn_m != 0; bd_n = 1'b0; end
      case (q.cmd)
         rau_pkg::CMD_NORM: st = reduce_frac(an_n, an_m, ad_n, ad_m, r);
         rau_pkg::CMD_ADD, rau_pkg::CMD_SUB, rau_pkg::CMD_CMP: begin
            mul_sm(an_n, an_m, bd_n, bd_m, n1, m1);
            mul_sm(bn_n, bn_m, ad_n, ad_m, n2, m2);
            if (q.cmd != rau_pkg::CMD_ADD && m2 != 0) n2 = !n2;
            add_sm(n1, m1, n2, m2, nn, nm);
            if (q.cmd == rau_pkg::CMD_CMP) begin
               r.less = nn && nm != 0;
               r.equal = nm == 0;
            end else begin
               mul_sm(ad_n, ad_m, bd_n, bd_m, dn, dm);
               st = reduce_frac(nn, nm, dn, dm, r);
            end
         end
         rau_pkg::CMD_MUL: begin
            mul_sm(an_n, an_m, bn_n, bn_m, nn, nm);
            mul_sm(ad_n, ad_m, bd_n, bd_m, dn, dm);
            st = reduce_frac(nn, nm, dn, dm, r);
         end
         default: begin
            if (bn_m == 0) st = rau_pkg::ST_DIV0;
            else begin
               mul_sm(an_n, an_m, bd_n, bd_m, nn, nm);
               mul_sm(ad_n, ad_m, bn_n, bn_m, dn, dm);
               st = reduce_frac(nn, nm, dn, dm, r);
            end
         end
      endcase
      if (st != rau_pkg::ST_OK) begin
         r.num = '0;
         r.den = '0;
      end
      r.status = st;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_count, what, got, want);
      error_count++;
   endtask

   // driver: presents the head of the pending queue, changes at falling edge
   always @(negedge clock) begin
      frac_req_type q;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_fire) begin
         // hold the transaction until taken
      end else if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
         q = pending_reqs.pop_front();
         req_tvalid <= 1'b1;
         req_tuser  <= q.cmd;
         req_tdata  <= {q.b_den, q.b_num, q.a_den, q.a_num};
      end else begin
         req_tvalid <= 1'b0;
      end
      rsp_tready <= reset ? 1'b0 : ($urandom_range(99) >= recv_stall_pct);
   end

   // monitor: predicts on accepted requests, checks accepted results
   always @(posedge clock) begin
      frac_req_type q;
      frac_rsp_type got;
      frac_rsp_type want;
      cycle_count++;
      req_fire <= !reset && req_tvalid && req_tready;
      if (!reset && req_tvalid && req_tready) begin
         q.cmd = req_tuser;
         {q.b_den, q.b_num, q.a_den, q.a_num} = req_tdata;
         expected_fracs.push_back(predict_frac(q));
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{num: rsp_tdata[31:0], den: rsp_tdata[62:32], less: rsp_tdata[63],
                 equal: rsp_tdata[64], status: rsp_tdata[66:65]};
         if (expected_fracs.size() == 0) begin
            report_mismatch("unexpected result", 64'(rsp_tdata), 64'd0);
         end else begin
            want = expected_fracs.pop_front();
            if (got.num != want.num) report_mismatch("res_num", 64'(got.num), 64'(want.num));
            if (got.den != want.den) report_mismatch("res_den", 64'(got.den), 64'(want.den));
            if (got.less != want.less)
               report_mismatch("less", 64'(got.less), 64'(want.less));
            if (got.equal != want.equal)
               report_mismatch("equal", 64'(got.equal), 64'(want.equal));
            if (got.status != want.status)
               report_mismatch("status", 64'(got.status), 64'(want.status));
         end
      end
      if (cycle_count > 1500000) begin
         $display("Verification failed");
         $finish;
      end
   end

   function automatic logic [31:0] rand_word();
      case ($urandom_range(7))
         0: return 32'(int'($urandom_range(20)) - 10);
         1: return 32'h8000_0000;
         2: return 32'h7FFF_FFFF;
         3: return 32'(int'($urandom_range(2000)) - 1000);
         4: return 32'(int'($urandom_range(200000)) - 100000);
         default: return $urandom();
      endcase
   endfunction

   task automatic add_req(input logic [2:0] c, input logic [31:0] an, input logic [31:0] ad,
                          input logic [31:0] bn, input logic [31:0] bd);
      frac_req_type q;
      q = '{cmd: c, a_num: an, a_den: ad, b_num: bn, b_den: bd};
      pending_reqs.push_back(q);
   endtask

   task automatic run_phase(input int count, input int idle_pct, input int stall_pct);
      logic [31:0] g;
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      for (int i = 0; i < count; i++) begin
         // shared factors make gcd reduction do real work
         g = 32'($urandom_range(50) + 1);
         if ($urandom_range(3) == 0)
            add_req(3'($urandom_range(7)), rand_word(), rand_word(), rand_word(), rand_word());
         else
            add_req(3'($urandom_range(5)), rand_word() * g, rand_word() * g,
                    rand_word(), ($urandom_range(9) == 0) ? 32'd0 : rand_word());
      end
      wait (pending_reqs.size() == 0 && !req_tvalid);
      wait (expected_fracs.size() == 0);
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = rau_pkg::CMD_NORM;
      rsp_tready = 1'b0;
      req_fire = 1'b0;
      error_count = 0;
      cycle_count = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      repeat (4) @(posedge clock);
      #1 reset = 1'b0;

      // directed: every operation, zero denominators, divide by zero, overflow, extremes
      add_req(rau_pkg::CMD_NORM, 32'd6, 32'hFFFF_FFFC, 32'd0, 32'd0);
      add_req(rau_pkg::CMD_NORM, 32'd0, 32'd5, 32'd1, 32'd1);
      add_req(rau_pkg::CMD_NORM, 32'd1, 32'd0, 32'd1, 32'd1);
      add_req(rau_pkg::CMD_NORM, 32'h8000_0000, 32'hFFFF_FFFF, 32'd1, 32'd1);
      add_req(rau_pkg::CMD_NORM, 32'h8000_0000, 32'd1, 32'd1, 32'd1);
      add_req(rau_pkg::CMD_NORM, 32'd1, 32'h8000_0000, 32'd1, 32'd1);
      add_req(rau_pkg::CMD_NORM, 32'hFFFF_FFFF, 32'h8000_0000, 32'd1, 32'd1);
      add_req(rau_pkg::CMD_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
      add_req(rau_pkg::CMD_ADD, 32'd1, 32'd2, 32'd1, 32'd0);
      add_req(rau_pkg::CMD_ADD, 32'h7FFF_FFFF, 32'd1, 32'h7FFF_FFFF, 32'd1);
      add_req(rau_pkg::CMD_SUB, 32'd3, 32'd4, 32'd3, 32'd4);
      add_req(rau_pkg::CMD_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
      add_req(rau_pkg::CMD_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      add_req(rau_pkg::CMD_MUL, 32'h7FFF_FFFF, 32'd3, 32'd3, 32'h7FFF_FFFF);
      add_req(rau_pkg::CMD_MUL, 32'd0, 32'hFFFF_FFFF, 32'd7, 32'd9);
      add_req(rau_pkg::CMD_DIV, 32'd1, 32'd2, 32'd0, 32'd5);
      add_req(rau_pkg::CMD_DIV, 32'hFFFF_FFFE, 32'd3, 32'd4, 32'hFFFF_FFFA);
      add_req(rau_pkg::CMD_DIV, 32'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd1);
      add_req(rau_pkg::CMD_CMP, 32'd1, 32'd3, 32'd2, 32'd6);
      add_req(rau_pkg::CMD_CMP, 32'hFFFF_FFFF, 32'd2, 32'd1, 32'd2);
      add_req(rau_pkg::CMD_CMP, 32'h8000_0000, 32'd1, 32'h7FFF_FFFF, 32'd1);
      add_req(rau_pkg::CMD_CMP, 32'd1, 32'd3, 32'd1, 32'd0);
      add_req(3'd6, 32'd1, 32'd2, 32'd3, 32'd4);
      add_req(3'd7, 32'd1, 32'd0, 32'd3, 32'd0);
      run_phase(0, 0, 0);

      run_phase(130, 0, 0);
      run_phase(110, 79, 0);
      run_phase(110, 0, 79);
      run_phase(100, 30, 30);

      repeat (400) @(posedge clock);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule
`default_nettype wire
